// ----- hdl/hcbp_pkg.sv -----
// Shared types and constants for the Huffman code bit packer.
`default_nettype none
package hcbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = $clog2(SYMBOL_COUNT);
  localparam int MAX_CODE_LEN = 32;
  localparam int CODE_W       = 32;
  // longest usable code: the length limit, but never past the code word
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LEN_W        = 6;
  localparam int PEND_W       = 7;
  localparam int CNT_W        = 3;
  localparam int ACC_W        = CODE_W + 8;
  localparam int REM_W        = 6;
  localparam int BYTE_W       = 8;
  localparam int IN_DATA_W    = 48;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  // One queued job for the packer.
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } q_entry_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- hdl/hcbp_front.sv -----
// Front end: takes input beats, owns the code table, queues encode/flush jobs.
`default_nettype none
module hcbp_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [1:0]                       s_tuser,
  input  logic [hcbp_pkg::IN_DATA_W-1:0]   s_tdata,
  output logic                             push,
  output hcbp_pkg::q_entry_t               push_data,
  input  hcbp_pkg::q_stat_t                q_stat
);
  import hcbp_pkg::*;

  logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];

  logic              s1_valid;
  logic              s1_flush;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;

  logic              accept;
  func_t             func;
  logic [SYM_W-1:0]  sym;
  logic [CODE_W-1:0] word_in;
  logic [LEN_W-1:0]  len_in;
  logic [LEN_W-1:0]  len_clamped;

  assign func    = func_t'(s_tuser);
  assign sym     = s_tdata[SYM_W-1:0];
  assign word_in = s_tdata[8 +: CODE_W];
  assign len_in  = s_tdata[8 + CODE_W +: LEN_W];
  assign len_clamped = (len_in > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : len_in;

  assign push     = s1_valid && !q_stat.full;
  assign s_tready = !s1_valid || !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  assign push_data.flush = s1_flush;
  assign push_data.code  = rd_code;
  assign push_data.len   = s1_flush ? '0 : rd_len;

  // table write and registered read
  always_ff @(posedge clk) begin
    if (accept && func == FUNC_LOAD) begin
      code_mem[sym] <= word_in;
      len_mem[sym]  <= len_clamped;
    end
    if (accept && func == FUNC_ENCODE) begin
      rd_code <= code_mem[sym];
      rd_len  <= len_mem[sym];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flush <= 1'b0;
    end else if (accept) begin
      case (func)
        FUNC_ENCODE: begin
          s1_valid <= 1'b1;
          s1_flush <= 1'b0;
        end
        FUNC_FLUSH: begin
          s1_valid <= 1'b1;
          s1_flush <= 1'b1;
        end
        default: begin
          s1_valid <= 1'b0;
        end
      endcase
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hcbp_queue.sv -----
// Short job queue between front and back.
`default_nettype none
module hcbp_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hcbp_pkg::q_entry_t push_data,
  output hcbp_pkg::q_stat_t  q_stat,
  output logic               head_valid,
  output hcbp_pkg::q_entry_t head_data,
  input  logic               pop
);
  import hcbp_pkg::*;

  q_entry_t            slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full = (count == Q_CNT_W'(Q_DEPTH));
  assign head_valid  = (count != '0);
  assign head_data   = slots[rd_ptr];
  assign do_push     = push && !q_stat.full;
  assign do_pop      = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/hcbp_back.sv -----
// Back end: merges codes into the bit accumulator and emits bytes.
`default_nettype none
module hcbp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  hcbp_pkg::q_entry_t head_data,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,
  output logic               m_tlast
);
  import hcbp_pkg::*;

  logic              busy;
  logic [ACC_W-1:0]  acc;
  logic [REM_W-1:0]  rem;
  logic [PEND_W-1:0] pending_bits;
  logic [CNT_W-1:0]  pending_count;

  logic [2*CODE_W-1:0] code_sh;
  logic [CODE_W-1:0]   code_al;
  logic [PEND_W-1:0]   pend_al;
  logic [ACC_W-1:0]    acc_enc;
  logic [REM_W-1:0]    rem_enc;
  logic [BYTE_W-1:0]   flush_byte;
  logic                slot_free;
  logic                emit;
  logic [ACC_W-1:0]    acc_shift;
  logic [REM_W-1:0]    rem_after;

  // leftover bits at the top of the word, returned right aligned
  function automatic logic [PEND_W-1:0] tail_bits(input logic [ACC_W-1:0] w,
                                                  input logic [CNT_W-1:0] n);
    tail_bits = w[ACC_W-1 -: PEND_W] >> (CNT_W'(PEND_W) - n);
  endfunction

  assign pop       = !busy && head_valid;
  assign slot_free = !m_tvalid || m_tready;
  assign emit      = busy && slot_free;

  // left-align code, then place it after the pending bits
  assign code_sh = {head_data.code, {CODE_W{1'b0}}} >> head_data.len;
  assign code_al = code_sh[CODE_W-1:0];
  assign pend_al = pending_bits << (CNT_W'(PEND_W) - pending_count);
  assign acc_enc = {pend_al, {(ACC_W-PEND_W){1'b0}}} | ({code_al, 8'b0} >> pending_count);
  assign rem_enc = {3'b0, pending_count} + head_data.len;
  assign flush_byte = BYTE_W'({1'b0, pending_bits} << (4'd8 - {1'b0, pending_count}));

  assign acc_shift = acc << 8;
  assign rem_after = rem - REM_W'(8);

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head_data.flush) begin
        acc <= {flush_byte, {CODE_W{1'b0}}};
        rem <= REM_W'(8);
      end else begin
        acc <= acc_enc;
        rem <= rem_enc;
      end
    end else if (emit) begin
      acc <= acc_shift;
      rem <= rem_after;
    end
    if (emit) begin
      m_tdata <= acc[ACC_W-1 -: BYTE_W];
      m_tlast <= (rem < REM_W'(16));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      m_tvalid      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (pop) begin
        if (head_data.flush) begin
          busy          <= (pending_count != '0);
          pending_bits  <= '0;
          pending_count <= '0;
        end else if (rem_enc >= REM_W'(8)) begin
          busy <= 1'b1;
        end else begin
          pending_bits  <= tail_bits(acc_enc, rem_enc[CNT_W-1:0]);
          pending_count <= rem_enc[CNT_W-1:0];
        end
      end else if (emit && rem < REM_W'(16)) begin
        busy          <= 1'b0;
        pending_bits  <= tail_bits(acc_shift, rem_after[CNT_W-1:0]);
        pending_count <= rem_after[CNT_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/huffman_code_bit_packer.sv -----
// Top level of the Huffman code bit packer.
//
// Input channel (s_*): one beat per command. s_tuser selects the command:
// load a code-table entry, encode a symbol, or flush. Loads only write the
// table; encodes append the symbol's code MSB first to a bit accumulator and
// emit every byte that fills; a flush emits the partial byte, zero padded,
// and clears the accumulator.
// Output channel (m_*): one byte per beat, earliest bit in bit 7. m_tlast
// marks the final byte produced by one encode or flush command.
// A command's first byte passes the table read register, a queue slot,
// the accumulator merge and the byte output register before it is presented.
// Loads do not occupy the packer. An encode or flush holds the packer for its
// merge and then for each output byte, which waits while the receiver
// stalls; a 32-bit code on seven pending bits gives four bytes. The packer
// takes the next job only after the last byte of the current one. A
// four-entry job queue lets the front keep taking commands while it works.
// Reset (rst, synchronous) empties the queue and the accumulator and drops
// any output beat; table contents are undefined until loaded.
// A receiver stall holds the output beat, fills the queue, and then drops
// s_tready.
`default_nettype none
module huffman_code_bit_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast    // last
);
  import hcbp_pkg::*;

  logic     push;
  q_entry_t push_data;
  q_stat_t  q_stat;
  logic     head_valid;
  q_entry_t head_data;
  logic     pop;

  hcbp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  hcbp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .q_stat     (q_stat),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  hcbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule
`default_nettype wire

// ----- hdl/hcbp_checker.sv -----
// Port-level checks for the Huffman code bit packer, bound to the top level.
`default_nettype none
module hcbp_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);
  import hcbp_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input beat changed while stalled");

  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a load leaves the pipe stage empty, so the next beat can be taken
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == FUNC_LOAD |=> s_tready)
    else $error("load blocked the input");

endmodule

bind huffman_code_bit_packer hcbp_checker u_hcbp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for huffman_code_bit_packer: table loads, MSB-first packing, flush.
`timescale 1ns / 1ps
module tb;
  import hcbp_pkg::*;

  // Code 3 on s_tuser is not a command; the block must drop it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_LIMIT = 5000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 165;
  localparam int REPORT_MAX = 10;

  typedef struct {
    logic [7:0] byte_val;
    logic       is_last;
  } packed_beat_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // symbol[7:0], code_word[39:8], code_length[45:40], zero pad
  logic [1:0]  s_tuser;   // func[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte[7:0]
  logic        m_tlast;   // last

  huffman_code_bit_packer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Mirror of the code table and the bit accumulator.
  logic [CODE_W-1:0] code_tab [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_tab  [SYMBOL_COUNT];
  logic [7:0]        loaded_syms [$];   // symbols safe to encode
  logic [PEND_W-1:0] pend_bits = '0;
  logic [CNT_W-1:0]  pend_cnt  = '0;

  packed_beat_t expected_bytes [$];   // bytes still owed by the DUT, oldest first
  int  errors = 0;
  bit  tx_idle_on = 1'b1;   // sender inserts random gaps
  bit  rx_idle_on = 1'b1;   // receiver inserts random stalls

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void note_error(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Work out the bytes one accepted command produces and queue them.
  function automatic void pack_command(logic [1:0] f, logic [7:0] sym,
                                       logic [CODE_W-1:0] cw, logic [LEN_W-1:0] ln);
    logic [7:0] acc;
    logic [3:0] cnt;
    int         first_idx;
    bit         seen;
    first_idx = expected_bytes.size();
    case (f)
      FUNC_LOAD: begin
        if (ln > MAX_CODE_LEN) ln = LEN_W'(MAX_CODE_LEN);
        if (ln > CODE_W) ln = LEN_W'(CODE_W);
        code_tab[sym] = cw;
        len_tab[sym]  = ln;
        seen = 1'b0;
        foreach (loaded_syms[i]) if (loaded_syms[i] == sym) seen = 1'b1;
        if (!seen) loaded_syms.push_back(sym);
      end
      FUNC_ENCODE: begin
        acc = {1'b0, pend_bits};
        cnt = {1'b0, pend_cnt};
        // Shift code bits in MSB first; every eighth bit closes a byte.
        for (int l = int'(len_tab[sym]) - 1; l >= 0; l--) begin
          acc = {acc[6:0], code_tab[sym][l]};
          cnt++;
          if (cnt == 4'd8) begin
            expected_bytes.push_back('{acc, 1'b0});
            acc = '0;
            cnt = '0;
          end
        end
        pend_bits = acc[6:0];
        pend_cnt  = cnt[2:0];
      end
      FUNC_FLUSH: begin
        // Partial byte goes out left aligned, zero padded below.
        if (pend_cnt != 0)
          expected_bytes.push_back('{8'({1'b0, pend_bits} << (8 - pend_cnt)), 1'b0});
        pend_bits = '0;
        pend_cnt  = '0;
      end
      default: ;
    endcase
    if (expected_bytes.size() > first_idx) expected_bytes[$].is_last = 1'b1;
  endfunction

  // Present one command beat and hold it until the DUT takes it.
  task automatic send_cmd(logic [1:0] f, logic [7:0] sym, logic [CODE_W-1:0] cw,
                          logic [LEN_W-1:0] ln);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {2'b00, ln, cw, sym};
    s_tuser  <= f;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pack_command(f, sym, cw, ln);
  endtask

  // Mostly short and mid codes, some empty, some full width, some overlong.
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(MAX_CODE_LEN + 1, 63));
    if (r <= 3) return LEN_W'(MAX_CODE_LEN);
    return LEN_W'($urandom_range(1, MAX_CODE_LEN - 1));
  endfunction

  // One random command; counts only if the DUT acts on it.
  task automatic send_random_item(output bit counted);
    int         pick;
    logic [7:0] sym;
    pick    = $urandom_range(0, 99);
    counted = 1'b1;
    if (pick < 12 || loaded_syms.size() == 0) begin
      send_cmd(FUNC_LOAD, 8'($urandom), $urandom, pick_length());
    end else if (pick < 85) begin
      // Only symbols with a loaded entry may be encoded.
      sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      send_cmd(FUNC_ENCODE, sym, $urandom, LEN_W'($urandom));
    end else if (pick < 95) begin
      send_cmd(FUNC_FLUSH, 8'($urandom), $urandom, LEN_W'($urandom));
    end else begin
      send_cmd(FUNC_UNUSED, 8'($urandom), $urandom, LEN_W'($urandom));
      counted = 1'b0;
    end
  endtask

  // Field extremes, all commands, clamping, zero length, empty and partial flush.
  task automatic test_directed_codes();
    send_cmd(FUNC_LOAD, 8'd0,   32'hFFFF_FFFF, 6'd32);
    send_cmd(FUNC_LOAD, 8'd255, 32'h0000_0001, 6'd1);
    send_cmd(FUNC_LOAD, 8'd1,   32'hDEAD_BEEF, 6'd0);
    send_cmd(FUNC_LOAD, 8'd2,   32'h8000_0001, 6'd63);
    send_cmd(FUNC_LOAD, 8'd3,   32'h0000_0055, 6'd7);
    send_cmd(FUNC_LOAD, 8'd4,   32'h1234_5678, 6'd33);
    send_cmd(FUNC_LOAD, 8'd5,   32'h0000_00A5, 6'd8);
    send_cmd(FUNC_FLUSH,  8'd0,   '0, '0);   // nothing pending
    send_cmd(FUNC_ENCODE, 8'd5,   '0, '0);   // exactly one byte
    send_cmd(FUNC_ENCODE, 8'd3,   '0, '0);   // leaves seven bits pending
    send_cmd(FUNC_ENCODE, 8'd0,   '0, '0);   // full width on seven pending
    send_cmd(FUNC_ENCODE, 8'd1,   '0, '0);   // zero length
    send_cmd(FUNC_FLUSH,  8'd0,   '0, '0);   // seven-bit partial
    send_cmd(FUNC_ENCODE, 8'd255, '0, '0);
    send_cmd(FUNC_FLUSH,  8'd255, '0, '0);   // one-bit partial
    send_cmd(FUNC_ENCODE, 8'd2,   '0, '0);   // clamped from 63
    send_cmd(FUNC_ENCODE, 8'd4,   '0, '0);   // clamped from 33
    send_cmd(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_cmd(FUNC_FLUSH,  8'd0,   '0, '0);
    send_cmd(FUNC_FLUSH,  8'd0,   '0, '0);
  endtask

  // Random table and command mix; idling switched off for some stretches.
  task automatic test_random_stream();
    int n;
    bit counted;
    n = 0;
    repeat (24) send_cmd(FUNC_LOAD, 8'($urandom), $urandom, pick_length());
    while (n < RANDOM_ITEMS) begin
      if (n % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      send_random_item(counted);
      if (counted) n++;
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Back-to-back commands against an always-ready receiver.
  task automatic test_full_rate();
    bit counted;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (40) send_random_item(counted);
    send_cmd(FUNC_FLUSH, '0, '0, '0);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver: random stall before each beat, then ready until one is taken.
  initial begin : rx_side
    int stall;
    m_tready <= 1'b0;
    forever begin
      stall = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each output beat with the oldest expected byte.
  always @(posedge clk) begin : check_beats
    packed_beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_bytes.size() == 0) begin
        note_error($sformatf("unexpected beat: byte=%02h last=%b", m_tdata, m_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (m_tdata !== want.byte_val)
          note_error($sformatf("byte: expected %02h, got %02h", want.byte_val, m_tdata));
        if (m_tlast !== want.is_last)
          note_error($sformatf("last: expected %b, got %b (byte %02h)",
                               want.is_last, m_tlast, m_tdata));
      end
    end
  end

  initial begin : main
    int waited;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= FUNC_LOAD;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_codes();
    test_random_stream();
    test_full_rate();

    s_tvalid <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    // Catch stray beats after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_bytes.size() != 0)
      note_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
